/* rtl/lif_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lif_pkg;

  localparam int NEURONS_DEF = 32;
  localparam int IN_IDX_W    = 5;
  localparam int VAL_W       = 16;
  localparam int DEG_W       = 6;
  localparam int MASK_W      = 32;
  localparam int REQ_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAK   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

  localparam logic [VAL_W-1:0]        LEAK_RST   = 16'd62259;
  localparam logic signed [VAL_W-1:0] THRESH_RST = 16'sd256;

  typedef enum logic [REQ_W-1:0] {
    REQ_INJECT = 3'd0,
    REQ_SET    = 3'd1,
    REQ_ADD    = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    RAM_CLEAR,
    RAM_REQ,
    RAM_TICK
  } ram_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INJ,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_TICK_SUM,
    ST_TICK_MUL,
    ST_TICK_UPD,
    ST_TICK_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     inject;
    logic     edge_upd;
    logic     tick_rd;
    logic     acc_clr;
    logic     mul;
    logic     upd;
    logic     commit;
    logic     emit;
    logic     clr_we;
    ram_sel_t ram_sel;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/lif_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lif_ram
  import lif_pkg::*;
#(
  parameter int WIDTH = VAL_W + 1,
  parameter int DEPTH = NEURONS_DEF * NEURONS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/lif_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module lif_ctrl
  import lif_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [REQ_W-1:0]                   req_type,
  output logic                                    busy,
  output cmd_t                                    cmd,
  output logic [$clog2(NEURONS)-1:0]              tick_s,
  output logic [$clog2(NEURONS)-1:0]              tick_d,
  output logic [$clog2(NEURONS*NEURONS)-1:0]      clr_addr
);

  localparam int IW    = $clog2(NEURONS);
  localparam int PAIRS = NEURONS * NEURONS;
  localparam int AW    = $clog2(PAIRS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(NEURONS - 1);
  localparam logic [AW-1:0] LAST_PAIR = AW'(PAIRS - 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] s_r, s_nxt;
  logic [IW-1:0] d_r, d_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      s_r     <= '0;
      d_r     <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
      d_r     <= d_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    s_nxt       = s_r;
    d_nxt       = d_r;
    clr_nxt     = clr_r;
    cmd         = '0;
    cmd.ram_sel = RAM_REQ;
    case (state_r)
      ST_CLEAR: begin
        cmd.ram_sel = RAM_CLEAR;
        cmd.clr_we  = 1'b1;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == LAST_PAIR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          s_nxt    = '0;
          d_nxt    = '0;
          case (req_type)
            REQ_INJECT:                   state_nxt = ST_INJ;
            REQ_SET, REQ_ADD, REQ_REMOVE: state_nxt = ST_EDGE_RD;
            REQ_TICK:                     state_nxt = ST_TICK_SUM;
            default:                      state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INJ: begin
        cmd.inject = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_EDGE_RD: begin
        state_nxt = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        cmd.edge_upd = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_TICK_SUM: begin
        cmd.ram_sel = RAM_TICK;
        cmd.tick_rd = 1'b1;
        cmd.acc_clr = (s_r == '0);
        if (s_r == LAST_IDX) begin
          state_nxt = ST_TICK_MUL;
        end else begin
          s_nxt = s_r + IW'(1);
        end
      end
      ST_TICK_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_TICK_UPD;
      end
      ST_TICK_UPD: begin
        cmd.upd = 1'b1;
        if (d_r == LAST_IDX) begin
          state_nxt = ST_TICK_END;
        end else begin
          d_nxt     = d_r + IW'(1);
          s_nxt     = '0;
          state_nxt = ST_TICK_SUM;
        end
      end
      ST_TICK_END: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy     = (state_r != ST_IDLE);
  assign tick_s   = s_r;
  assign tick_d   = d_r;
  assign clr_addr = clr_r;

endmodule
`default_nettype wire

/* rtl/lif_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lif_datapath
  import lif_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cmd_t                                 cmd,
  input  wire logic [$clog2(NEURONS)-1:0]           tick_s,
  input  wire logic [$clog2(NEURONS)-1:0]           tick_d,
  input  wire logic [$clog2(NEURONS*NEURONS)-1:0]   clr_addr,
  input  wire logic [REQ_W-1:0]                     in_req_type,
  input  wire logic [IN_IDX_W-1:0]                  in_neuron_index,
  input  wire logic [IN_IDX_W-1:0]                  in_target_index,
  input  wire logic signed [VAL_W-1:0]              in_value_in,
  input  wire logic                                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
  input  wire logic [CFG_W-1:0]                     cfg_data,
  output logic                                      out_strobe,
  output logic [MASK_W-1:0]                         out_spike_mask,
  output logic signed [VAL_W-1:0]                   out_membrane_level,
  output logic [DEG_W-1:0]                          out_out_degree
);

  localparam int IW    = $clog2(NEURONS);
  localparam int PAIRS = NEURONS * NEURONS;
  localparam int AW    = $clog2(PAIRS);
  localparam int RW    = VAL_W + 1;
  localparam int ACC_W = VAL_W + IW;
  localparam logic [AW-1:0]       N_A   = AW'(NEURONS);
  localparam logic [IN_IDX_W:0]   N_LIM = (IN_IDX_W + 1)'(NEURONS);

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [31:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  logic [REQ_W-1:0]        req_r;
  logic [IN_IDX_W-1:0]     src_r, dst_r;
  logic signed [VAL_W-1:0] val_r;
  logic [VAL_W-1:0]        leak_r;
  logic signed [VAL_W-1:0] thr_r;
  logic signed [VAL_W-1:0] mem_r [NEURONS];
  logic [DEG_W-1:0]        deg_r [NEURONS];
  logic [NEURONS-1:0]      fired_r, newf_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [32:0]      prod_r, prod_nxt;
  logic                    tick_v_r;
  logic [IW-1:0]           tick_s_r;
  logic                    out_strobe_r;
  logic [MASK_W-1:0]       out_mask_r;
  logic signed [VAL_W-1:0] out_mem_r;
  logic [DEG_W-1:0]        out_deg_r;

  logic                    src_ok, dst_ok, pair_ok;
  logic [IW-1:0]           src_i, dst_i, mrd_i;
  logic [AW-1:0]           req_addr, tick_addr, ram_addr;
  logic                    ram_we;
  logic [RW-1:0]           ram_wd, ram_rd;
  logic                    rd_present;
  logic [VAL_W-1:0]        rd_w;
  logic                    deg_inc, deg_dec;
  logic signed [VAL_W-1:0] mem_cur;
  logic [DEG_W-1:0]        deg_cur;
  logic signed [VAL_W-1:0] inj_val;
  logic signed [16:0]      leak_s;
  logic signed [33:0]      rnd;
  logic signed [17:0]      leaked;
  logic signed [VAL_W-1:0] inc_sat;
  logic signed [VAL_W-1:0] m_new;
  logic                    fire;

  assign src_ok  = ({1'b0, src_r} < N_LIM);
  assign dst_ok  = ({1'b0, dst_r} < N_LIM);
  assign pair_ok = src_ok && dst_ok;
  assign src_i   = src_r[IW-1:0];
  assign dst_i   = dst_r[IW-1:0];

  assign req_addr  = AW'(AW'(src_i) * N_A + AW'(dst_i));
  assign tick_addr = AW'(AW'(tick_s) * N_A + AW'(tick_d));

  assign rd_present = ram_rd[VAL_W];
  assign rd_w       = ram_rd[VAL_W-1:0];

  always_comb begin
    ram_addr = req_addr;
    case (cmd.ram_sel)
      RAM_CLEAR: ram_addr = clr_addr;
      RAM_TICK:  ram_addr = tick_addr;
      default:   ram_addr = req_addr;
    endcase
  end

  always_comb begin
    ram_we  = 1'b0;
    ram_wd  = {1'b1, val_r};
    deg_inc = 1'b0;
    deg_dec = 1'b0;
    if (cmd.clr_we) begin
      ram_we = 1'b1;
      ram_wd = '0;
    end else if (cmd.edge_upd) begin
      case (req_r)
        REQ_SET: begin
          ram_we  = pair_ok;
          deg_inc = pair_ok && !rd_present;
        end
        REQ_ADD: begin
          ram_we  = pair_ok && !rd_present;
          deg_inc = pair_ok && !rd_present;
        end
        REQ_REMOVE: begin
          ram_we  = pair_ok && rd_present;
          ram_wd  = {1'b0, rd_w};
          deg_dec = pair_ok && rd_present;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  lif_ram #(
    .WIDTH (RW),
    .DEPTH (PAIRS)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  assign mrd_i   = cmd.mul ? tick_d : src_i;
  assign mem_cur = mem_r[mrd_i];
  assign deg_cur = deg_r[src_i];
  assign inj_val = sat16(32'(mem_cur) + 32'(val_r));

  assign leak_s   = {1'b0, leak_r};
  assign prod_nxt = mem_cur * leak_s;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (tick_v_r && fired_r[tick_s_r] && rd_present) begin
      acc_nxt = acc_r + ACC_W'($signed(rd_w));
    end
  end

  assign rnd     = 34'(prod_r) + 34'sd32768;
  assign leaked  = rnd[33:16];
  assign inc_sat = sat16(32'(acc_r));
  assign m_new   = sat16(32'(leaked) + 32'(inc_sat));
  assign fire    = (m_new >= thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r       <= LEAK_RST;
      thr_r        <= THRESH_RST;
      mem_r        <= '{default: '0};
      deg_r        <= '{default: '0};
      fired_r      <= '0;
      newf_r       <= '0;
      tick_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEAK:   leak_r <= cfg_data;
          CFG_THRESH: thr_r  <= cfg_data;
          default:    leak_r <= leak_r;
        endcase
      end
      if (cmd.inject && src_ok) begin
        mem_r[src_i] <= inj_val;
      end
      if (deg_inc) begin
        deg_r[src_i] <= deg_cur + DEG_W'(1);
      end else if (deg_dec) begin
        deg_r[src_i] <= deg_cur - DEG_W'(1);
      end
      if (cmd.load) begin
        newf_r <= '0;
      end else if (cmd.upd) begin
        mem_r[tick_d]  <= fire ? '0 : m_new;
        newf_r[tick_d] <= fire;
      end
      if (cmd.commit) begin
        fired_r <= newf_r;
      end
      tick_v_r     <= cmd.tick_rd;
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      src_r <= in_neuron_index;
      dst_r <= in_target_index;
      val_r <= in_value_in;
    end
    acc_r    <= acc_nxt;
    tick_s_r <= tick_s;
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      out_mask_r <= MASK_W'(fired_r);
      out_mem_r  <= src_ok ? mem_cur : '0;
      out_deg_r  <= src_ok ? deg_cur : '0;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_spike_mask     = out_mask_r;
  assign out_membrane_level = out_mem_r;
  assign out_out_degree     = out_deg_r;

endmodule
`default_nettype wire

/* rtl/lif_spiking_network_step_top.sv */
// Leaky integrate-and-fire network step engine. Pulse start while busy is low to
// hand over one request; exactly one result beat follows, shown for a single cycle
// with out_strobe high, and it cannot be held off, so capture it when it appears.
// After reset the block sweeps the edge store clear with busy high. An inject request
// passes through an inject state before the result beat, and an edge request through
// a read and a write state of the edge store. A tick reads the single-port edge memory
// once per neuron pair, runs the leak multiply and membrane update for each neuron,
// then commits the spike mask. busy drops in the cycle the result beat is shown.
// Configuration writes are taken at any cycle but must only be issued while no
// request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module lif_spiking_network_step_top
  import lif_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [REQ_W-1:0]        in_req_type,
  input  wire logic [IN_IDX_W-1:0]     in_neuron_index,
  input  wire logic [IN_IDX_W-1:0]     in_target_index,
  input  wire logic signed [VAL_W-1:0] in_value_in,
  output logic                         out_strobe,
  output logic [MASK_W-1:0]            out_spike_mask,
  output logic signed [VAL_W-1:0]      out_membrane_level,
  output logic [DEG_W-1:0]             out_out_degree,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  localparam int IW = $clog2(NEURONS);
  localparam int AW = $clog2(NEURONS * NEURONS);

  cmd_t          cmd;
  logic [IW-1:0] tick_s, tick_d;
  logic [AW-1:0] clr_addr;

  lif_ctrl #(
    .NEURONS (NEURONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .busy     (busy),
    .cmd      (cmd),
    .tick_s   (tick_s),
    .tick_d   (tick_d),
    .clr_addr (clr_addr)
  );

  lif_datapath #(
    .NEURONS (NEURONS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .tick_s             (tick_s),
    .tick_d             (tick_d),
    .clr_addr           (clr_addr),
    .in_req_type        (in_req_type),
    .in_neuron_index    (in_neuron_index),
    .in_target_index    (in_target_index),
    .in_value_in        (in_value_in),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_spike_mask     (out_spike_mask),
    .out_membrane_level (out_membrane_level),
    .out_out_degree     (out_out_degree)
  );

endmodule
`default_nettype wire
